/* sv/trial_division_prime_filter_top_assert.svh */
// assertion macros for the prime filter checker
// no dependencies; included by tdpf_checker
`ifndef TRIAL_DIVISION_PRIME_FILTER_TOP_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_FILTER_TOP_ASSERT_SVH

// checked only while out of reset
`define TDPF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// checked at every edge, reset included
`define TDPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tdpf_pkg.sv */
// shared types and constants for the trial division prime filter
// no dependencies
package tdpf_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  // how the front end sorted an item
  typedef enum logic [1:0] {
    CLS_NOT_PRIME = 2'd0,
    CLS_PRIME     = 2'd1,
    CLS_TEST      = 2'd2
  } tdpf_cls_t;

  typedef struct packed {
    logic      list_end;
    tdpf_cls_t cls;
  } tdpf_tag_t;

endpackage

/* sv/tdpf_front.sv */
// front end: accepts input beats, sorts them and queues them for the back end
// depends on tdpf_pkg
module tdpf_front import tdpf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_list_end,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic        [VALUE_BITS-1:0] q_value,
  output tdpf_tag_t                    q_tag
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS-1:0] val_q_r [QUEUE_DEPTH];
  tdpf_tag_t             tag_q_r [QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  push, pop;
  logic [VALUE_BITS-1:0] raw;
  tdpf_tag_t             tag_new;

  assign raw = in_value;

  always_comb begin
    tag_new.list_end = in_list_end;
    if (raw[VALUE_BITS-1] || raw < VALUE_BITS'(2)) begin
      tag_new.cls = CLS_NOT_PRIME;
    end else if (raw == VALUE_BITS'(2) || raw == VALUE_BITS'(3)) begin
      tag_new.cls = CLS_PRIME;
    end else begin
      tag_new.cls = CLS_TEST;
    end
  end

  assign in_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_value  = val_q_r[rd_ptr_r];
  assign q_tag    = tag_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_q_r[wr_ptr_r] <= raw;
      tag_q_r[wr_ptr_r] <= tag_new;
    end
  end

endmodule

/* sv/tdpf_back.sv */
// back end: trial division sequencer with a bit-serial remainder unit
// and the output register; depends on tdpf_pkg
module tdpf_back import tdpf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic        [VALUE_BITS-1:0] q_value,
  input  tdpf_tag_t                    q_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_prime_value,
  output logic                         out_is_prime,
  output logic                         out_list_end_res
);

  localparam int W  = VALUE_BITS;
  localparam int CW = $clog2(W);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_STEP = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [W-1:0]  val_r, val_nxt;
  logic          last_r, last_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    sq_r, sq_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          out_valid_r;
  logic [W-1:0]  out_value_r;
  logic          out_is_prime_r, out_list_end_r;

  logic          out_free;
  logic          emit;
  logic [W-1:0]  emit_value;
  logic          emit_prime, emit_last;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;

  assign out_free = !out_valid_r || out_ready;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, dvd_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_comb begin
    state_nxt  = state_r;
    val_nxt    = val_r;
    last_nxt   = last_r;
    d_nxt      = d_r;
    sq_nxt     = sq_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    cnt_nxt    = cnt_r;
    q_ready    = 1'b0;
    emit       = 1'b0;
    emit_value = val_r;
    emit_prime = 1'b0;
    emit_last  = last_r;
    unique case (state_r)
      ST_IDLE: begin
        emit_value = q_value;
        emit_last  = q_tag.list_end;
        if (q_valid) begin
          if (q_tag.cls == CLS_TEST) begin
            q_ready   = 1'b1;
            val_nxt   = q_value;
            last_nxt  = q_tag.list_end;
            d_nxt     = W'(2);
            sq_nxt    = (W+1)'(4);
            state_nxt = ST_SQ;
          end else if (out_free) begin
            q_ready    = 1'b1;
            emit_prime = (q_tag.cls == CLS_PRIME);
            emit       = emit_prime || q_tag.list_end;
          end
        end
      end
      ST_SQ: begin
        if (sq_r > {1'b0, val_r}) begin
          // no divisor up to the square root: prime
          if (out_free) begin
            emit       = 1'b1;
            emit_prime = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          rem_nxt   = '0;
          dvd_nxt   = val_r;
          cnt_nxt   = CW'(W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (rem_r == '0) begin
          // composite: only a list end gives a beat
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          d_nxt     = d_r + W'(1);
          // (d+1)^2 = d^2 + 2d + 1
          sq_nxt    = sq_r + {d_r, 1'b1};
          state_nxt = ST_SQ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    cnt_r  <= cnt_nxt;
    if (emit) begin
      out_value_r    <= emit_value;
      out_is_prime_r <= emit_prime;
      out_list_end_r <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prime_value  = $signed(out_value_r);
  assign out_is_prime     = out_is_prime_r;
  assign out_list_end_res = out_list_end_r;

endmodule

/* sv/trial_division_prime_filter_top.sv */
// Trial division prime filter, top level.
// Input channel: in_value (signed) and in_list_end, valid/ready.
// Result channel: out_prime_value, out_is_prime, out_list_end_res, valid/ready.
// A result beat is given for every prime value and for every value marked
// last of its list (then is_prime tells whether it was prime); composite
// values that are not a list end give no beat.
// The front end sorts each beat and holds up to two in a queue, so input is
// taken while the back end searches. Negative values, 0, 1, 2 and 3 need no
// division and are settled by the back end without a search.
// Other values try divisors 2, 3, ... while d*d <= value; each try runs the
// bit-serial remainder unit over all VALUE_BITS bits of the value, and the
// back end takes no new item from the queue until it returns to idle.
// Reset (synchronous, active low) empties the queue and the output register.
// When the receiver stalls, the result waits in the output register while
// the back end starts the next item; it stops with a second result ready or at a
// value that needs no division, and the queue then fills and drops in_ready.
module trial_division_prime_filter_top import tdpf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_list_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_prime_value,
  output logic                         out_is_prime,
  output logic                         out_list_end_res
);

  logic                  q_valid, q_ready;
  logic [VALUE_BITS-1:0] q_value;
  tdpf_tag_t             q_tag;

  tdpf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .in_list_end (in_list_end),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_value     (q_value),
    .q_tag       (q_tag)
  );

  tdpf_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_value          (q_value),
    .q_tag            (q_tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_prime_value  (out_prime_value),
    .out_is_prime     (out_is_prime),
    .out_list_end_res (out_list_end_res)
  );

endmodule

/* sv/tdpf_checker.sv */
// port-level checks for the prime filter, bound to the top level
// depends on tdpf_pkg and trial_division_prime_filter_top_assert.svh
`include "trial_division_prime_filter_top_assert.svh"

module tdpf_checker import tdpf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic signed [VALUE_BITS-1:0] in_value,
  input logic                         in_list_end,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] out_prime_value,
  input logic                         out_is_prime,
  input logic                         out_list_end_res
);

  // a waiting input beat holds
  `TDPF_ASSERT(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_value) && $stable(in_list_end), "input beat changed while waiting")

  // a stalled result beat holds
  `TDPF_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_prime_value) && $stable(out_is_prime) && $stable(out_list_end_res), "result beat changed while stalled")

  // a prime is positive, above one, and odd unless it is two
  `TDPF_ASSERT(a_prime_range, clk, rst_n, out_valid && out_is_prime |-> !out_prime_value[VALUE_BITS-1] && out_prime_value != VALUE_BITS'(0) && out_prime_value != VALUE_BITS'(1) && (out_prime_value[0] || out_prime_value == VALUE_BITS'(2)), "prime flag on a value that cannot be prime")

  // a non-prime beat only ever marks a list end
  `TDPF_ASSERT(a_nonprime_end, clk, rst_n, out_valid && !out_is_prime |-> out_list_end_res, "composite beat without list end")

  // reset clears the result channel
  `TDPF_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind trial_division_prime_filter_top tdpf_checker #(.VALUE_BITS(VALUE_BITS)) u_tdpf_checker (.*);

/* sim/tb_trial_division_prime_filter_top.sv */
// testbench for trial_division_prime_filter_top: directed and random beats checked
// against a trial-division predictor kept in a small scoreboard class
// depends on tdpf_pkg and the top level RTL
module tb_trial_division_prime_filter_top;
  import tdpf_pkg::*;

  localparam int VW           = VALUE_BITS_DEF;
  localparam int LIMIT_CYCLES = 4_000_000;
  // slowest search is 181*181, which tries every divisor up to 181
  localparam int DRAIN_CYCLES = 4000;
  localparam int RAND_ITEMS   = 118;

  class prime_scoreboard;
    typedef struct {
      logic signed [VW-1:0] value;
      bit                   prime;
      bit                   last;
    } filter_result_t;

    filter_result_t pending_results[$];
    logic [VW-1:0]  candidate;
    int             stop_divisor;
    int             errors;
    int             beats_in;
    int             results_out;
    int             primes_seen;
    int             list_ends_seen;

    function new();
      candidate    = '0;
      stop_divisor = 2;
      errors       = 0;
      beats_in     = 0;
      results_out  = 0;
      primes_seen  = 0;
      list_ends_seen = 0;
    endfunction

    // trial division on the raw bits, negative values never prime
    function bit search_prime(logic [VW-1:0] raw);
      int v;
      int d;
      candidate    = raw;
      stop_divisor = 2;
      if (raw[VW-1]) return 1'b0;
      v = int'(raw);
      if (v < 2) return 1'b0;
      for (d = 2; d * d <= v; d++) begin
        stop_divisor = d;
        if (v % d == 0) return 1'b0;
      end
      stop_divisor = d;
      return 1'b1;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task note_input(logic signed [VW-1:0] value, bit last);
      filter_result_t r;
      beats_in++;
      r.value = value;
      r.prime = search_prime(value);
      r.last  = last;
      if (r.prime || r.last) begin
        pending_results.push_back(r);
        if (r.prime) primes_seen++;
        if (r.last) list_ends_seen++;
      end
    endtask

    task check_result(logic signed [VW-1:0] value, logic prime, logic last);
      filter_result_t r;
      results_out++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result beat value=%0d is_prime=%0b list_end=%0b",
                         value, prime, last));
        return;
      end
      r = pending_results.pop_front();
      if (value !== r.value)
        report($sformatf("prime_value %0d, expected %0d", value, r.value));
      if (prime !== r.prime)
        report($sformatf("is_prime %0b for value %0d, expected %0b", prime, r.value, r.prime));
      if (last !== r.last)
        report($sformatf("list_end_res %0b for value %0d, expected %0b", last, r.value, r.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [VW-1:0] in_value;
  logic                 in_list_end;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [VW-1:0] out_prime_value;
  logic                 out_is_prime;
  logic                 out_list_end_res;

  prime_scoreboard filter_sb = new();
  int cycle_count = 0;
  int burst_left  = 0;

  trial_division_prime_filter_top #(.VALUE_BITS(VW)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_list_end      (in_list_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_prime_value  (out_prime_value),
    .out_is_prime     (out_is_prime),
    .out_list_end_res (out_list_end_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               filter_sb.pending_results.size());
      $display("FAIL trial_division_prime_filter_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) filter_sb.note_input(in_value, in_list_end);
      if (out_valid && out_ready)
        filter_sb.check_result(out_prime_value, out_is_prime, out_list_end_res);
    end
  end

  // receiver: stall pattern re-picked each time the phase counter wraps, sometimes always ready
  initial begin
    logic [15:0] stall_pat;
    int          phase;
    out_ready = 1'b0;
    stall_pat = 16'hffff;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (phase == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hffff;
          1: stall_pat = 16'h0001;
          default: stall_pat = 16'($urandom()) | 16'h0001;
        endcase
      end
      out_ready <= stall_pat[phase % 16];
      phase = (phase + 1) % 64;
    end
  end

  // one beat, with bursts and gaps decided by the sender
  task automatic drive_beat(input logic signed [VW-1:0] value, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(50, 400);
      else if ($urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_value    <= value;
    in_list_end <= last;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // mostly small values so searches stay short, a few full range
  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return VW'($urandom_range(0, 200));
      4, 5:       return VW'($urandom_range(0, 2000));
      6:          return VW'($urandom_range(0, 32767));
      7:          return VW'(-$urandom_range(1, 32768));
      8:          return VW'($urandom_range(0, 65535));
      default:    return VW'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    logic signed [VW-1:0] dir_values[];
    bit                   dir_last[];
    int                   list_len;
    int                   n;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_value    = '0;
    in_list_end = 1'b0;
    dir_values = {-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5,
                  16'sd9, 16'sd25, 16'sd32767, 16'sd32749, 16'sd32761, 16'sd2, 16'sd3,
                  16'sd4, -16'sd7, 16'sd0, 16'sd1, 16'sd97, 16'sd91, 16'sd21845};
    dir_last   = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                  1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_values[i]) drive_beat(dir_values[i], dir_last[i]);

    // random lists: a run of values, the last one usually marked
    n = 0;
    while (n < RAND_ITEMS) begin
      list_len = $urandom_range(1, 7);
      for (int k = 0; k < list_len; k++) begin
        drive_beat(pick_value(), (k == list_len - 1) && ($urandom_range(0, 7) != 0));
        n++;
      end
    end
    in_valid <= 1'b0;

    while (filter_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d beats (%0d random), checked %0d results: %0d primes, %0d list ends",
             filter_sb.beats_in, n, filter_sb.results_out, filter_sb.primes_seen,
             filter_sb.list_ends_seen);
    $display("covered negatives, 0, 1, 2, 3, squares, the top of the range and %0d cycles",
             cycle_count);
    if (filter_sb.errors == 0) begin
      $display("PASS trial_division_prime_filter_top");
    end else begin
      $display("%0d mismatches", filter_sb.errors);
      $display("FAIL trial_division_prime_filter_top");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/tdpf_pkg.sv
sv/tdpf_front.sv
sv/tdpf_back.sv
sv/trial_division_prime_filter_top.sv
sv/tdpf_checker.sv
sim/tb_trial_division_prime_filter_top.sv
